// ----- rtl/core/va3_pkg.sv -----
// Shared types and constants of the three-component vector ALU.
package va3_pkg;

   typedef enum logic [2:0] {
      CMD_ADD   = 3'd0,
      CMD_SUB   = 3'd1,
      CMD_CROSS = 3'd2,
      CMD_DOT   = 3'd3,
      CMD_SCALE = 3'd4,
      CMD_DIV   = 3'd5,
      CMD_MAG   = 3'd6,
      CMD_NORM  = 3'd7
   } va3_cmd_type;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // Per-beat sideband that rides alongside the arithmetic down the pipe.
   typedef struct packed {
      va3_cmd_type      cmd;
      logic             pt;
      logic             ov;
      logic             dz;
      logic             go;   // quotient lanes supply the vector result
      logic             neg;  // divisor is negative
      logic [2:0][31:0] a;
      logic [31:0]      s;
      logic [2:0][31:0] v;
      logic [31:0]      sc;
   } va3_side_type;

   typedef struct packed {
      logic [2:0][31:0] v;
      logic [31:0]      sc;
      logic             pt;
      logic             ov;
      logic             dz;
   } va3_rsp_type;

endpackage

// ----- rtl/core/va3_sqrt.sv -----
// Pipelined integer square root, 64-bit radicand, one root bit per stage.
module va3_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  va3_pkg::va3_side_type in_side,
   input  logic [63:0]          in_sq,
   output logic                 out_vld,
   output va3_pkg::va3_side_type out_side,
   output logic [31:0]          out_root
);

   localparam int STEPS = 32;

   logic                  vld_ff  [STEPS+1];
   va3_pkg::va3_side_type side_ff [STEPS+1];
   logic [34:0]           r_ff    [STEPS+1];
   logic [31:0]           q_ff    [STEPS+1];
   logic [63:0]           n_ff    [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         r_ff[0]    <= '0;
         q_ff[0]    <= '0;
         n_ff[0]    <= in_sq;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [34:0] r_in;
      logic [31:0] q_in;
      logic [34:0] rr;
      logic [34:0] t;

      always_comb begin
         rr = {r_ff[k][32:0], n_ff[k][63:62]};
         t  = {1'b0, q_ff[k], 2'b01};
         if (rr >= t) begin
            r_in = rr - t;
            q_in = {q_ff[k][30:0], 1'b1};
         end else begin
            r_in = rr;
            q_in = {q_ff[k][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            r_ff[k+1]    <= r_in;
            q_ff[k+1]    <= q_in;
            n_ff[k+1]    <= {n_ff[k][61:0], 2'b00};
         end
      end
   end

   assign out_vld  = vld_ff[STEPS];
   assign out_side = side_ff[STEPS];
   assign out_root = q_ff[STEPS];

endmodule

// ----- rtl/core/va3_div.sv -----
// Three-lane pipelined restoring divider for (a << FRAC_BITS) / d with saturation.
module va3_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  va3_pkg::va3_side_type in_side,
   input  logic [31:0]          in_den,
   output logic                 out_vld,
   output va3_pkg::va3_side_type out_side,
   output logic [2:0][31:0]     out_q,
   output logic                 out_ov
);

   localparam int NW    = 32 + FRAC_BITS;  // numerator magnitude width
   localparam int HW    = NW - 33;         // bits above the 33 worked bits
   localparam int STEPS = 33;

   logic                  vld_ff  [STEPS+1];
   va3_pkg::va3_side_type side_ff [STEPS+1];
   logic [31:0]           den_ff  [STEPS+1];
   logic [31:0]           r_ff    [STEPS+1][3];
   logic [32:0]           q_ff    [STEPS+1][3];
   logic [32:0]           n_ff    [STEPS+1][3];
   logic                  sgn_ff  [STEPS+1][3];
   logic                  big_ff  [STEPS+1][3];

   // front stage: magnitudes, early overflow check, remainder seed
   logic [31:0] r0_in   [3];
   logic [32:0] n0_in   [3];
   logic        sgn0_in [3];
   logic        big0_in [3];

   always_comb begin
      logic [31:0]   mag;
      logic [NW-1:0] nn;
      logic [31:0]   hi;
      for (int i = 0; i < 3; i++) begin
         mag = in_side.a[i][31] ? (~in_side.a[i] + 32'd1) : in_side.a[i];
         nn  = {mag, {FRAC_BITS{1'b0}}};
         hi  = {{(32-HW){1'b0}}, nn[NW-1:33]};
         big0_in[i] = (hi >= in_den);
         r0_in[i]   = big0_in[i] ? 32'd0 : hi;
         n0_in[i]   = nn[32:0];
         sgn0_in[i] = in_side.a[i][31] ^ in_side.neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         den_ff[0]  <= in_den;
         for (int i = 0; i < 3; i++) begin
            r_ff[0][i]   <= r0_in[i];
            q_ff[0][i]   <= '0;
            n_ff[0][i]   <= n0_in[i];
            sgn_ff[0][i] <= sgn0_in[i];
            big_ff[0][i] <= big0_in[i];
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [31:0] r_in [3];
      logic [32:0] q_in [3];

      always_comb begin
         logic [32:0] rr;
         logic [32:0] dd;
         dd = {1'b0, den_ff[k]};
         for (int i = 0; i < 3; i++) begin
            rr = {r_ff[k][i], n_ff[k][i][32]};
            if (rr >= dd) begin
               r_in[i] = 32'(rr - dd);
               q_in[i] = {q_ff[k][i][31:0], 1'b1};
            end else begin
               r_in[i] = rr[31:0];
               q_in[i] = {q_ff[k][i][31:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
            den_ff[k+1]  <= den_ff[k];
            for (int i = 0; i < 3; i++) begin
               r_ff[k+1][i]   <= r_in[i];
               q_ff[k+1][i]   <= q_in[i];
               n_ff[k+1][i]   <= {n_ff[k][i][31:0], 1'b0};
               sgn_ff[k+1][i] <= sgn_ff[k][i];
               big_ff[k+1][i] <= big_ff[k][i];
            end
         end
      end
   end

   // back stage: apply sign, clamp to the 32-bit range
   logic [2:0][31:0] q_in;
   logic             ov_in;

   always_comb begin
      logic [32:0] q;
      logic [32:0] qn;
      ov_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         q  = q_ff[STEPS][i];
         qn = ~q + 33'd1;
         if (big_ff[STEPS][i]) begin
            q_in[i] = sgn_ff[STEPS][i] ? va3_pkg::SAT_MIN : va3_pkg::SAT_MAX;
            ov_in   = 1'b1;
         end else if (!sgn_ff[STEPS][i]) begin
            if (q > {1'b0, va3_pkg::SAT_MAX}) begin
               q_in[i] = va3_pkg::SAT_MAX;
               ov_in   = 1'b1;
            end else begin
               q_in[i] = q[31:0];
            end
         end else begin
            if (q > {1'b0, va3_pkg::SAT_MIN}) begin
               q_in[i] = va3_pkg::SAT_MIN;
               ov_in   = 1'b1;
            end else begin
               q_in[i] = qn[31:0];
            end
         end
      end
   end

   logic                  out_vld_ff;
   va3_pkg::va3_side_type out_side_ff;
   logic [2:0][31:0]      out_q_ff;
   logic                  out_ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side_ff <= side_ff[STEPS];
         out_q_ff    <= q_in;
         out_ov_ff   <= ov_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_side = out_side_ff;
   assign out_q    = out_q_ff;
   assign out_ov   = out_ov_ff;

endmodule

// ----- rtl/core/vector3_alu.sv -----
// Top level of the pipelined three-component Q16.16 vector ALU.
//
// Usage
//  - Request channel (req_*): one beat carries an opcode, vectors a and b, a
//    scalar and the point flag. A beat is taken when req_valid is high and
//    req_stall is low.
//  - Response channel (rsp_*): exactly one beat per request, in order,
//    carrying rx/ry/rz, scalar_out and the point, overflow and div_zero flags.
//  - Throughput: one beat per cycle for every opcode mix while req_stall is low.
//  - Path: every opcode takes the same path from the request register to
//    rsp_valid, through the 32-stage square-root pipe feeding the 33-stage
//    divider, which normalize needs in series; other opcodes ride along.
//  - Reset (synchronous, active high) clears every valid bit; the pipe empties
//    and no response beat is shown until new requests arrive.
//  - Stall: the response register is backed by one skid register. While the
//    skid is empty the pipe keeps moving, so a request is still taken in the
//    cycle a response first stalls; once the skid holds a beat, req_stall
//    rises and the whole pipe freezes, losing and repeating nothing.
module vector3_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   input  logic signed [31:0] req_scalar_in,
   input  logic               req_is_point,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rx,
   output logic signed [31:0] rsp_ry,
   output logic signed [31:0] rsp_rz,
   output logic signed [31:0] rsp_scalar_out,
   output logic               rsp_point_out,
   output logic               rsp_overflow,
   output logic               rsp_div_zero
);

   // clamp a wide signed value to 32 bits; top bit flags saturation
   function automatic logic [32:0] sat66(input logic signed [65:0] v);
      logic [32:0] res;
      if (v > $signed({{34{1'b0}}, va3_pkg::SAT_MAX})) begin
         res = {1'b1, va3_pkg::SAT_MAX};
      end else if (v < $signed({{34{1'b1}}, va3_pkg::SAT_MIN})) begin
         res = {1'b1, va3_pkg::SAT_MIN};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

   logic skid_vld_ff;
   logic en;

   // the pipe only advances while the skid register is free
   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // ---- stage 1: capture the request beat
   va3_pkg::va3_side_type s1_in;
   logic                  s1_vld_ff;
   va3_pkg::va3_side_type s1_ff;
   logic [2:0][31:0]      s1_b_ff;

   always_comb begin
      s1_in      = '0;
      s1_in.cmd  = va3_pkg::va3_cmd_type'(req_cmd);
      s1_in.pt   = req_is_point;
      s1_in.a[0] = req_ax;
      s1_in.a[1] = req_ay;
      s1_in.a[2] = req_az;
      s1_in.s    = req_scalar_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s1_in;
         s1_b_ff <= {req_bz, req_by, req_bx};
      end
   end

   // ---- stage 2: six shared 32x32 multipliers, add/sub lanes
   logic signed [31:0] mx     [6];
   logic signed [31:0] my     [6];
   logic signed [63:0] prod   [6];
   logic signed [32:0] as_in  [3];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         mx[k] = '0;
         my[k] = '0;
      end
      case (s1_ff.cmd)
         va3_pkg::CMD_CROSS: begin
            mx[0] = s1_ff.a[1]; my[0] = s1_b_ff[2];
            mx[1] = s1_ff.a[2]; my[1] = s1_b_ff[1];
            mx[2] = s1_ff.a[2]; my[2] = s1_b_ff[0];
            mx[3] = s1_ff.a[0]; my[3] = s1_b_ff[2];
            mx[4] = s1_ff.a[0]; my[4] = s1_b_ff[1];
            mx[5] = s1_ff.a[1]; my[5] = s1_b_ff[0];
         end
         va3_pkg::CMD_DOT: begin
            for (int i = 0; i < 3; i++) begin
               mx[2*i] = s1_ff.a[i];
               my[2*i] = s1_b_ff[i];
            end
         end
         va3_pkg::CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               mx[2*i] = s1_ff.a[i];
               my[2*i] = s1_ff.s;
            end
         end
         va3_pkg::CMD_MAG, va3_pkg::CMD_NORM: begin
            for (int i = 0; i < 3; i++) begin
               mx[2*i] = s1_ff.a[i];
               my[2*i] = s1_ff.a[i];
            end
         end
         default: begin
         end
      endcase
      for (int k = 0; k < 6; k++) begin
         prod[k] = mx[k] * my[k];
      end
      for (int i = 0; i < 3; i++) begin
         if (s1_ff.cmd == va3_pkg::CMD_SUB) begin
            as_in[i] = $signed(s1_ff.a[i]) - $signed(s1_b_ff[i]);
         end else begin
            as_in[i] = $signed(s1_ff.a[i]) + $signed(s1_b_ff[i]);
         end
      end
   end

   logic                  s2_vld_ff;
   va3_pkg::va3_side_type s2_ff;
   logic signed [63:0]    s2_p_ff  [6];
   logic signed [32:0]    s2_as_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff    <= s1_ff;
         s2_p_ff  <= prod;
         s2_as_ff <= as_in;
      end
   end

   // ---- stage 3: combine products (exact, pre-shift)
   logic signed [65:0] w_in [3];
   logic               sh_in;
   logic [63:0]        sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_in[i] = '0;
      end
      sh_in = 1'b0;
      sq_in = '0;
      case (s2_ff.cmd)
         va3_pkg::CMD_ADD, va3_pkg::CMD_SUB: begin
            for (int i = 0; i < 3; i++) begin
               w_in[i] = s2_as_ff[i];
            end
         end
         va3_pkg::CMD_CROSS: begin
            w_in[0] = s2_p_ff[0] - s2_p_ff[1];
            w_in[1] = s2_p_ff[2] - s2_p_ff[3];
            w_in[2] = s2_p_ff[4] - s2_p_ff[5];
            sh_in   = 1'b1;
         end
         va3_pkg::CMD_DOT: begin
            w_in[0] = s2_p_ff[0] + s2_p_ff[2] + s2_p_ff[4];
            sh_in   = 1'b1;
         end
         va3_pkg::CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               w_in[i] = s2_p_ff[2*i];
            end
            sh_in = 1'b1;
         end
         va3_pkg::CMD_MAG, va3_pkg::CMD_NORM: begin
            // squares are non-negative and their sum fits 64 bits
            sq_in = $unsigned(s2_p_ff[0]) + $unsigned(s2_p_ff[2]) + $unsigned(s2_p_ff[4]);
         end
         default: begin
         end
      endcase
   end

   logic                  s3_vld_ff;
   va3_pkg::va3_side_type s3_ff;
   logic signed [65:0]    s3_w_ff [3];
   logic                  s3_sh_ff;
   logic [63:0]           s3_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff    <= s2_ff;
         s3_w_ff  <= w_in;
         s3_sh_ff <= sh_in;
         s3_sq_ff <= sq_in;
      end
   end

   // ---- stage 4: floor shift and saturate the direct results
   va3_pkg::va3_side_type s4_in;

   always_comb begin
      logic signed [65:0] t;
      logic [32:0]        st [3];
      for (int i = 0; i < 3; i++) begin
         t     = s3_sh_ff ? (s3_w_ff[i] >>> FRAC_BITS) : s3_w_ff[i];
         st[i] = sat66(t);
      end
      s4_in = s3_ff;
      case (s3_ff.cmd)
         va3_pkg::CMD_ADD, va3_pkg::CMD_SUB, va3_pkg::CMD_CROSS, va3_pkg::CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               s4_in.v[i] = st[i][31:0];
            end
            s4_in.ov = st[0][32] | st[1][32] | st[2][32];
         end
         va3_pkg::CMD_DOT: begin
            s4_in.sc = st[0][31:0];
            s4_in.ov = st[0][32];
            s4_in.pt = 1'b0;
         end
         va3_pkg::CMD_MAG: begin
            s4_in.pt = 1'b0;
         end
         default: begin
         end
      endcase
   end

   logic                  s4_vld_ff;
   va3_pkg::va3_side_type s4_ff;
   logic [63:0]           s4_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff    <= s4_in;
         s4_sq_ff <= s3_sq_ff;
      end
   end

   // ---- square root pipe
   logic                  rt_vld;
   va3_pkg::va3_side_type rt_side;
   logic [31:0]           rt_root;

   va3_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s4_vld_ff),
      .in_side  (s4_ff),
      .in_sq    (s4_sq_ff),
      .out_vld  (rt_vld),
      .out_side (rt_side),
      .out_root (rt_root)
   );

   // ---- stage 5: magnitude result, divisor select, zero-divisor check
   va3_pkg::va3_side_type s5_in;
   logic [31:0]           den_in;

   always_comb begin
      s5_in  = rt_side;
      den_in = '0;
      case (rt_side.cmd)
         va3_pkg::CMD_MAG: begin
            s5_in.sc = rt_root[31] ? va3_pkg::SAT_MAX : rt_root;
            s5_in.ov = rt_root[31];
         end
         va3_pkg::CMD_NORM: begin
            s5_in.sc = rt_root[31] ? va3_pkg::SAT_MAX : rt_root;
            s5_in.ov = rt_root[31];
            den_in   = rt_root;
            if (rt_root == '0) begin
               s5_in.dz = 1'b1;
            end else begin
               s5_in.go = 1'b1;
            end
         end
         va3_pkg::CMD_DIV: begin
            den_in = rt_side.s[31] ? (~rt_side.s + 32'd1) : rt_side.s;
            if (rt_side.s == '0) begin
               s5_in.dz = 1'b1;
            end else begin
               s5_in.go  = 1'b1;
               s5_in.neg = rt_side.s[31];
            end
         end
         default: begin
         end
      endcase
   end

   logic                  s5_vld_ff;
   va3_pkg::va3_side_type s5_ff;
   logic [31:0]           s5_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= rt_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff     <= s5_in;
         s5_den_ff <= den_in;
      end
   end

   // ---- divider pipe
   logic                  dv_vld;
   va3_pkg::va3_side_type dv_side;
   logic [2:0][31:0]      dv_q;
   logic                  dv_ov;

   va3_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s5_vld_ff),
      .in_side  (s5_ff),
      .in_den   (s5_den_ff),
      .out_vld  (dv_vld),
      .out_side (dv_side),
      .out_q    (dv_q),
      .out_ov   (dv_ov)
   );

   // ---- merge and response register with skid
   va3_pkg::va3_rsp_type rsp_in;

   always_comb begin
      rsp_in.v  = dv_side.go ? dv_q : dv_side.v;
      rsp_in.sc = dv_side.sc;
      rsp_in.pt = dv_side.pt;
      rsp_in.ov = dv_side.ov | (dv_side.go & dv_ov);
      rsp_in.dz = dv_side.dz;
   end

   logic                 out_vld_ff;
   va3_pkg::va3_rsp_type out_ff;
   va3_pkg::va3_rsp_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (!rsp_stall) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || !rsp_stall) begin
         out_vld_ff <= dv_vld;
      end else if (dv_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (!rsp_stall) begin
            out_ff <= skid_ff;
         end
      end else if (!out_vld_ff || !rsp_stall) begin
         out_ff <= rsp_in;
      end else begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_rx         = out_ff.v[0];
   assign rsp_ry         = out_ff.v[1];
   assign rsp_rz         = out_ff.v[2];
   assign rsp_scalar_out = out_ff.sc;
   assign rsp_point_out  = out_ff.pt;
   assign rsp_overflow   = out_ff.ov;
   assign rsp_div_zero   = out_ff.dz;

endmodule
